### src/tga_rle_pixel_decoder_assert.svh
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: assertion macros
// Shorthand for the concurrent checks of the decoder, clocked on clock and
// held off during reset.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Register indexes, reset values and chunk header constants.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 32;
   localparam int DIM_WIDTH           = 16;
   localparam int PRODUCT_WIDTH       = 2 * DIM_WIDTH;

   typedef logic [1:0]           csr_index_type;
   typedef logic [7:0]           byte_type;
   typedef logic [DIM_WIDTH-1:0] dim_type;

   localparam csr_index_type REG_IMAGE_WIDTH     = 2'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT    = 2'd1;
   localparam csr_index_type REG_HAS_ALPHA       = 2'd2;
   localparam csr_index_type REG_RUN_LENGTH_MODE = 2'd3;

   localparam dim_type RESET_IMAGE_WIDTH  = 16'd256;
   localparam dim_type RESET_IMAGE_HEIGHT = 16'd256;

   // Position of the last stored byte of a pixel.
   localparam logic [1:0] LAST_BYTE_RGB  = 2'd2;
   localparam logic [1:0] LAST_BYTE_RGBA = 2'd3;

   // A header at or above this value starts a repeated pixel.
   localparam byte_type REPEAT_HEADER_MIN = 8'd128;
   localparam byte_type REPEAT_BIAS       = 8'd127;

endpackage

### src/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Turns the body of a TGA image into RGB(A) pixels with repeat counts.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock while no result is held up at
// the output: a byte is held in an input register, decoded from there, and a
// finished pixel sits in the result register until it is taken. Header bytes
// and the leading bytes of a pixel give no result; the byte that completes a
// pixel gives one result with its repeat count, clipped to the pixels left in
// the image. After the pixel that ends the image the decoder waits, in
// run-length mode, for a new chunk header. The pixel total is recomputed from
// the size registers each cycle and registered before the decoder sees it.
`include "tga_rle_pixel_decoder_assert.svh"

module tga_rle_pixel_decoder
   import tga_rle_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,

   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_red,
   output logic [7:0]    rsp_green,
   output logic [7:0]    rsp_blue,
   output logic [7:0]    rsp_alpha,
   output logic [7:0]    rsp_repeat_count,
   output logic          rsp_last_of_image,

   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  dim_type       csr_write_data
);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Configuration registers.
   dim_type image_width_ff;
   dim_type image_height_ff;
   logic    has_alpha_ff;
   logic    run_length_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff     <= RESET_IMAGE_WIDTH;
         image_height_ff    <= RESET_IMAGE_HEIGHT;
         has_alpha_ff       <= 1'b0;
         run_length_mode_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:     image_width_ff     <= csr_write_data;
            REG_IMAGE_HEIGHT:    image_height_ff    <= csr_write_data;
            REG_HAS_ALPHA:       has_alpha_ff       <= csr_write_data[0];
            REG_RUN_LENGTH_MODE: run_length_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Pixel total, saturated to the counter width and registered after the
   // multiplier.
   logic [PRODUCT_WIDTH-1:0] product;
   logic                     product_sat;
   count_type                total_ff;
   count_type                total_in;

   always_comb begin
      product     = image_width_ff * image_height_ff;
      product_sat = (PRODUCT_WIDTH > COUNT_WIDTH) && ((product >> COUNT_WIDTH) != '0);
      total_in    = product_sat ? '1 : product[COUNT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // Input register.
   logic     in_valid_ff;
   byte_type in_byte_ff;
   logic     out_valid_ff;
   logic     slot_free;
   logic     advance;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && slot_free;
   assign req_ready = !in_valid_ff || slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Decoder state.
   logic        expect_header_ff, expect_header_in;
   logic        run_is_repeat_ff, run_is_repeat_in;
   byte_type    run_left_ff, run_left_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   byte_type    pixel_ff [4];
   byte_type    pixel_in [4];
   count_type   done_ff, done_in;

   logic        header_phase;
   logic        produce;
   logic [1:0]  last_idx;
   byte_type    count_raw;
   byte_type    count_clip;
   count_type   remaining;
   logic        last;

   always_comb begin
      expect_header_in = expect_header_ff;
      run_is_repeat_in = run_is_repeat_ff;
      run_left_in      = run_left_ff;
      byte_idx_in      = byte_idx_ff;
      done_in          = done_ff;
      pixel_in         = pixel_ff;
      produce          = 1'b0;
      count_raw        = 8'd1;
      count_clip       = 8'd1;
      remaining        = count_type'(1);
      last             = 1'b0;
      last_idx         = has_alpha_ff ? LAST_BYTE_RGBA : LAST_BYTE_RGB;
      header_phase     = run_length_mode_ff && expect_header_ff;

      if (header_phase) begin
         run_is_repeat_in = (in_byte_ff >= REPEAT_HEADER_MIN);
         run_left_in      = (in_byte_ff >= REPEAT_HEADER_MIN) ?
                            in_byte_ff - REPEAT_BIAS : in_byte_ff + 8'd1;
         expect_header_in = 1'b0;
         byte_idx_in      = 2'd0;
      end else begin
         pixel_in[byte_idx_ff] = in_byte_ff;
         if (byte_idx_ff < last_idx) begin
            byte_idx_in = byte_idx_ff + 2'd1;
         end else begin
            byte_idx_in = 2'd0;
            produce     = 1'b1;
            if (run_length_mode_ff) begin
               if (run_left_ff == 8'd0) begin
                  // No run open: the pixel stands alone.
                  expect_header_in = 1'b1;
               end else if (run_is_repeat_ff) begin
                  count_raw        = run_left_ff;
                  run_left_in      = 8'd0;
                  expect_header_in = 1'b1;
               end else begin
                  run_left_in = run_left_ff - 8'd1;
                  if (run_left_ff == 8'd1) begin
                     expect_header_in = 1'b1;
                  end
               end
            end

            remaining  = (total_ff > done_ff) ? total_ff - done_ff : count_type'(1);
            count_clip = (count_type'(count_raw) > remaining) ?
                         remaining[7:0] : count_raw;
            last       = (count_type'(count_clip) == remaining);
            done_in    = done_ff + count_type'(count_clip);

            // End of image: re-arm for the next one.
            if (last) begin
               done_in          = '0;
               run_left_in      = 8'd0;
               byte_idx_in      = 2'd0;
               expect_header_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_is_repeat_ff <= 1'b0;
         run_left_ff      <= 8'd0;
         byte_idx_ff      <= 2'd0;
         done_ff          <= '0;
      end else if (advance) begin
         expect_header_ff <= expect_header_in;
         run_is_repeat_ff <= run_is_repeat_in;
         run_left_ff      <= run_left_in;
         byte_idx_ff      <= byte_idx_in;
         done_ff          <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   // Result register.
   byte_type red_ff;
   byte_type green_ff;
   byte_type blue_ff;
   byte_type alpha_ff;
   byte_type repeat_count_ff;
   logic     last_of_image_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= in_valid_ff && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         red_ff           <= pixel_in[2];
         green_ff         <= pixel_in[1];
         blue_ff          <= pixel_in[0];
         alpha_ff         <= has_alpha_ff ? pixel_in[3] : 8'd0;
         repeat_count_ff  <= count_clip;
         last_of_image_ff <= last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_alpha         = alpha_ff;
   assign rsp_repeat_count  = repeat_count_ff;
   assign rsp_last_of_image = last_of_image_ff;

   logic count_ok;
   logic end_of_image;
   logic rearmed;

   assign count_ok     = (rsp_repeat_count != 8'd0) && (rsp_repeat_count <= 8'd128);
   assign end_of_image = advance && produce && last;
   assign rearmed      = (done_ff == '0) && expect_header_ff;

   `TGA_ASSERT_SAME(a_stall_holds_input, !req_ready, in_valid_ff, "input stalled while empty")
   `TGA_ASSERT_SAME(a_count_range, rsp_valid, count_ok, "repeat count out of range")
   `TGA_ASSERT_NEXT(a_rearm_at_end, end_of_image, rearmed, "no re-arm after last pixel")

endmodule

### tb/tga_rle_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: result checker
// Watches the register writes and both channels of the decoder. It decodes
// every body byte it sees accepted into the pixel that the decoder should
// emit, and compares each result transaction with the oldest decoded pixel.
// ----------------------------------------------------------------------------
module tga_rle_pixel_checker
   import tga_rle_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   input  logic          req_ready,
   input  logic [7:0]    req_data_byte,

   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [7:0]    rsp_red,
   input  logic [7:0]    rsp_green,
   input  logic [7:0]    rsp_blue,
   input  logic [7:0]    rsp_alpha,
   input  logic [7:0]    rsp_repeat_count,
   input  logic          rsp_last_of_image,

   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  dim_type       csr_write_data,

   output int            mismatch_count,
   output int            pixels_outstanding
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       last_of_image;
   } decoded_pixel_type;

   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

   dim_type           cfg_width;
   dim_type           cfg_height;
   logic              cfg_alpha;
   logic              cfg_rle;

   logic              want_header;
   logic              run_repeat;
   logic [7:0]        run_left;
   logic [1:0]        byte_pos;
   byte_type          stored [4];
   logic [63:0]       pixels_done;

   decoded_pixel_type expected_pixels [$];

   initial begin
      mismatch_count     = 0;
      pixels_outstanding = 0;
   end

   function automatic void decode_byte(input byte_type value);
      logic [1:0]        last_pos;
      logic [63:0]       total;
      logic [63:0]       remaining;
      logic [63:0]       count;
      decoded_pixel_type pixel;
      last_pos = cfg_alpha ? LAST_BYTE_RGBA : LAST_BYTE_RGB;

      if (cfg_rle && want_header) begin
         if (value < REPEAT_HEADER_MIN) begin
            run_repeat = 1'b0;
            run_left   = value + 8'd1;
         end else begin
            run_repeat = 1'b1;
            run_left   = value - REPEAT_BIAS;
         end
         want_header = 1'b0;
         byte_pos    = 2'd0;
         return;
      end

      stored[byte_pos] = value;
      // A pixel also completes when the alpha setting shrank it mid-pixel.
      if (byte_pos < last_pos) begin
         byte_pos = byte_pos + 2'd1;
         return;
      end
      byte_pos = 2'd0;

      if (!cfg_rle) begin
         count = 64'd1;
      end else if (run_left == 8'd0) begin
         count       = 64'd1;
         want_header = 1'b1;
      end else if (run_repeat) begin
         count       = 64'(run_left);
         run_left    = 8'd0;
         want_header = 1'b1;
      end else begin
         count    = 64'd1;
         run_left = run_left - 8'd1;
         if (run_left == 8'd0) want_header = 1'b1;
      end

      total = 64'(cfg_width) * 64'(cfg_height);
      if (total > COUNT_MAX) total = COUNT_MAX;
      // An empty image, or one already passed, ends on the next pixel.
      remaining = (total > pixels_done) ? total - pixels_done : 64'd1;
      if (count > remaining) count = remaining;
      pixels_done = (pixels_done + count) & COUNT_MAX;

      pixel.red           = stored[2];
      pixel.green         = stored[1];
      pixel.blue          = stored[0];
      pixel.alpha         = cfg_alpha ? stored[3] : 8'd0;
      pixel.repeat_count  = count[7:0];
      pixel.last_of_image = (count == remaining);

      if (pixel.last_of_image) begin
         pixels_done = '0;
         run_left    = 8'd0;
         byte_pos    = 2'd0;
         want_header = 1'b1;
      end
      expected_pixels.push_back(pixel);
   endfunction

   always @(posedge clock) begin : check_proc
      decoded_pixel_type want;
      decoded_pixel_type got;
      if (reset) begin
         cfg_width   = RESET_IMAGE_WIDTH;
         cfg_height  = RESET_IMAGE_HEIGHT;
         cfg_alpha   = 1'b0;
         cfg_rle     = 1'b1;
         want_header = 1'b1;
         run_repeat  = 1'b0;
         run_left    = 8'd0;
         byte_pos    = 2'd0;
         pixels_done = '0;
         for (int i = 0; i < 4; i++) stored[i] = 8'd0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_IMAGE_WIDTH:     cfg_width  = csr_write_data;
               REG_IMAGE_HEIGHT:    cfg_height = csr_write_data;
               REG_HAS_ALPHA:       cfg_alpha  = csr_write_data[0];
               REG_RUN_LENGTH_MODE: cfg_rle    = csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count,
                   rsp_last_of_image};
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result transaction with no pixel outstanding: %p",
                           $realtime, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: pixel mismatch: expected r=%h g=%h b=%h a=%h n=%0d last=%b,",
                              $realtime, want.red, want.green, want.blue, want.alpha,
                              want.repeat_count, want.last_of_image,
                              " got r=%h g=%h b=%h a=%h n=%0d last=%b",
                              got.red, got.green, got.blue, got.alpha,
                              got.repeat_count, got.last_of_image);
               end
            end
         end

         if (req_valid && req_ready) decode_byte(req_data_byte);
      end
      pixels_outstanding = expected_pixels.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder: testbench top
// Feeds image bodies to the decoder under a range of image sizes, pixel
// formats and modes, with random idling on both channels, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
   import tga_rle_pkg::*;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_ready;
   logic [7:0]    req_data_byte    = 8'd0;
   logic          rsp_valid;
   logic          rsp_ready        = 1'b1;
   logic [7:0]    rsp_red;
   logic [7:0]    rsp_green;
   logic [7:0]    rsp_blue;
   logic [7:0]    rsp_alpha;
   logic [7:0]    rsp_repeat_count;
   logic          rsp_last_of_image;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index        = REG_IMAGE_WIDTH;
   dim_type       csr_write_data   = '0;

   int            mismatch_count;
   int            pixels_outstanding;
   int            bytes_sent       = 0;
   int            ready_hold       = 0;
   bit            idling_on        = 1'b1;
   bit            cur_alpha        = 1'b0;
   bit            cur_rle          = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tga_rle_pixel_decoder #(
      .COUNT_WIDTH(DEFAULT_COUNT_WIDTH)
   ) u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_data_byte,
      .rsp_valid, .rsp_ready, .rsp_red, .rsp_green, .rsp_blue, .rsp_alpha,
      .rsp_repeat_count, .rsp_last_of_image,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   tga_rle_pixel_checker #(
      .COUNT_WIDTH(DEFAULT_COUNT_WIDTH)
   ) u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_data_byte,
      .rsp_valid, .rsp_ready, .rsp_red, .rsp_green, .rsp_blue, .rsp_alpha,
      .rsp_repeat_count, .rsp_last_of_image,
      .csr_write_enable, .csr_index, .csr_write_data,
      .mismatch_count, .pixels_outstanding
   );

   // The result side stalls in bursts while idling is on.
   always @(negedge clock) begin
      if (ready_hold > 0)
         ready_hold--;
      else if (idling_on && $urandom_range(0, 9) == 0)
         ready_hold = $urandom_range(1, 16);
      rsp_ready <= (ready_hold == 0);
   end

   task automatic send_byte(input byte_type value);
      int gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     = 1'b1;
      req_data_byte = value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_pixel();
      repeat (cur_alpha ? 4 : 3) send_byte(byte_type'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed chunks with random content; now and then loose bytes.
   task automatic send_chunk();
      int n;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) send_byte(byte_type'($urandom_range(0, 255)));
      end else if (!cur_rle) begin
         send_pixel();
      end else if ($urandom_range(0, 1) == 1) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
         send_byte(byte_type'(REPEAT_BIAS + n));
         send_pixel();
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4);
         send_byte(byte_type'(n - 1));
         repeat (n) send_pixel();
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input dim_type value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Waits until every decoded pixel has come out, then lets any header byte
   // still in the pipeline settle.
   task automatic drain_decoder();
      @(negedge clock);
      req_valid = 1'b0;
      while (pixels_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_image(input dim_type w, input dim_type h, input bit alpha,
                            input bit rle);
      dim_type flag;
      drain_decoder();
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
      // Only bit 0 of the flag registers counts; the rest is random filler.
      flag    = dim_type'($urandom);
      flag[0] = alpha;
      write_csr(REG_HAS_ALPHA, flag);
      flag    = dim_type'($urandom);
      flag[0] = rle;
      write_csr(REG_RUN_LENGTH_MODE, flag);
      cur_alpha = alpha;
      cur_rle   = rle;
   endtask

   initial begin : timeout_proc
      #8_000_000;
      $display("tga_rle_pixel_decoder verification failed");
      $finish;
   end

   initial begin : stimulus_proc
      int phase_start;
      int wait_cycles;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Raw chunk of one pixel, then the longest repeat run, with extreme bytes.
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h7F);

      // The pixel count carried over already passes the new small image, so
      // the first run ends it at once; the second run overshoots and is clipped.
      set_image(16'd2, 16'd3, 1'b1, 1'b1);
      send_byte(8'h87);
      send_pixel();
      send_byte(8'h87);
      send_pixel();

      // Alpha switched off, then on, in the middle of a pixel.
      send_byte(8'h02);
      repeat (3) send_byte(byte_type'($urandom_range(0, 255)));
      drain_decoder();
      write_csr(REG_HAS_ALPHA, 16'h0000);
      cur_alpha = 1'b0;
      send_byte(byte_type'($urandom_range(0, 255)));
      repeat (2) send_byte(byte_type'($urandom_range(0, 255)));
      drain_decoder();
      write_csr(REG_HAS_ALPHA, 16'h0001);
      cur_alpha = 1'b1;
      repeat (2) send_byte(byte_type'($urandom_range(0, 255)));

      for (int phase = 0; phase < 12; phase++) begin
         if (phase >= 10) idling_on = 1'b0;
         case (phase)
            0:       set_image(16'd1, 16'd1, 1'b1, 1'b1);
            1:       set_image(16'd0, 16'd9, 1'b0, 1'b1);
            2:       set_image(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
            3:       set_image(16'd5, 16'd3, 1'b0, 1'b0);
            4:       set_image(16'hFFFF, 16'd1, 1'b0, 1'b1);
            5:       set_image(16'd4, 16'd0, 1'b1, 1'b0);
            default: set_image(dim_type'($urandom_range(0, 12)),
                               dim_type'($urandom_range(1, 12)),
                               1'($urandom_range(0, 1)),
                               $urandom_range(0, 3) != 0);
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 100) send_chunk();
      end

      @(negedge clock);
      req_valid = 1'b0;
      for (wait_cycles = 0; pixels_outstanding != 0 && wait_cycles < 20000; wait_cycles++)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && pixels_outstanding == 0)
         $display("tga_rle_pixel_decoder verification clean");
      else
         $display("tga_rle_pixel_decoder verification failed");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/tga_rle_pkg.sv
src/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_checker.sv
tb/tb_top.sv
